/* rtl/pwmix_pkg.sv */
// ----------------------------------------------------------------------------
// pwmix_pkg
// Shared types, scale increments and wave tables for the wavetable mixer.
// ----------------------------------------------------------------------------
package pwmix_pkg;

  localparam int unsigned GATE_BITS   = 8;
  localparam int unsigned SCALE_COLS  = 8;
  localparam int          MIX_OFFSET  = 1024;
  localparam int          MIX_MAX     = 2047;
  localparam int unsigned DAC_SHIFT   = 3;
  localparam int unsigned PHASE_W     = 16;
  localparam int unsigned ROM_IDX_W   = 8;
  localparam int unsigned SQUARE_EDGE = 144;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2
  } wave_kind_t;

  typedef enum logic [1:0] {
    SCALE_MAJOR      = 2'd0,
    SCALE_MINOR      = 2'd1,
    SCALE_DORIAN     = 2'd2,
    SCALE_MIXOLYDIAN = 2'd3
  } scale_t;

  // Stage load enables broadcast to every lane.
  typedef struct packed {
    logic accept;
    logic en2;
    logic en3;
    logic en4;
  } stage_ctrl_t;

  // Seventh-octave phase increments.
  localparam int unsigned D_C7  = 5689;
  localparam int unsigned D_D7  = 6386;
  localparam int unsigned D_E7  = 7168;
  localparam int unsigned D_F7  = 7594;
  localparam int unsigned D_FS7 = 8046;
  localparam int unsigned D_G7  = 8524;
  localparam int unsigned D_A7  = 9568;
  localparam int unsigned D_B7  = 10740;

  localparam logic [PHASE_W-1:0] STEP_MAJOR [SCALE_COLS] = '{
    16'(D_C7 >> 3), 16'(D_D7 >> 3), 16'(D_E7 >> 3), 16'(D_F7 >> 3),
    16'(D_G7 >> 3), 16'(D_A7 >> 3), 16'(D_B7 >> 3), 16'(D_C7 >> 2)
  };
  localparam logic [PHASE_W-1:0] STEP_MINOR [SCALE_COLS] = '{
    16'(D_A7 >> 3), 16'(D_B7 >> 3), 16'(D_C7 >> 2), 16'(D_D7 >> 2),
    16'(D_E7 >> 2), 16'(D_F7 >> 2), 16'(D_G7 >> 2), 16'(D_A7 >> 2)
  };
  localparam logic [PHASE_W-1:0] STEP_DORIAN [SCALE_COLS] = '{
    16'(D_A7 >> 3), 16'(D_B7 >> 3), 16'(D_C7 >> 2), 16'(D_D7 >> 2),
    16'(D_E7 >> 2), 16'(D_FS7 >> 2), 16'(D_G7 >> 2), 16'(D_A7 >> 2)
  };
  localparam logic [PHASE_W-1:0] STEP_MIXO [SCALE_COLS] = '{
    16'(D_G7 >> 3), 16'(D_A7 >> 3), 16'(D_B7 >> 3), 16'(D_C7 >> 2),
    16'(D_D7 >> 2), 16'(D_E7 >> 2), 16'(D_F7 >> 2), 16'(D_G7 >> 2)
  };

  // First half of the sine cycle; second half is the negation.
  localparam logic signed [7:0] SINE_HALF [128] = '{
      8'sd0,   8'sd3,   8'sd6,   8'sd9,  8'sd12,  8'sd15,  8'sd18,  8'sd21,
     8'sd24,  8'sd27,  8'sd30,  8'sd33,  8'sd36,  8'sd39,  8'sd42,  8'sd45,
     8'sd48,  8'sd51,  8'sd54,  8'sd57,  8'sd59,  8'sd62,  8'sd65,  8'sd67,
     8'sd70,  8'sd73,  8'sd75,  8'sd78,  8'sd80,  8'sd82,  8'sd85,  8'sd87,
     8'sd89,  8'sd91,  8'sd94,  8'sd96,  8'sd98, 8'sd100, 8'sd102, 8'sd103,
    8'sd105, 8'sd107, 8'sd108, 8'sd110, 8'sd112, 8'sd113, 8'sd114, 8'sd116,
    8'sd117, 8'sd118, 8'sd119, 8'sd120, 8'sd121, 8'sd122, 8'sd123, 8'sd123,
    8'sd124, 8'sd125, 8'sd125, 8'sd126, 8'sd126, 8'sd126, 8'sd126, 8'sd126,
    8'sd127, 8'sd126, 8'sd126, 8'sd126, 8'sd126, 8'sd126, 8'sd125, 8'sd125,
    8'sd124, 8'sd123, 8'sd123, 8'sd122, 8'sd121, 8'sd120, 8'sd119, 8'sd118,
    8'sd117, 8'sd116, 8'sd114, 8'sd113, 8'sd112, 8'sd110, 8'sd108, 8'sd107,
    8'sd105, 8'sd103, 8'sd102, 8'sd100,  8'sd98,  8'sd96,  8'sd94,  8'sd91,
     8'sd89,  8'sd87,  8'sd85,  8'sd82,  8'sd80,  8'sd78,  8'sd75,  8'sd73,
     8'sd70,  8'sd67,  8'sd65,  8'sd62,  8'sd59,  8'sd57,  8'sd54,  8'sd51,
     8'sd48,  8'sd45,  8'sd42,  8'sd39,  8'sd36,  8'sd33,  8'sd30,  8'sd27,
     8'sd24,  8'sd21,  8'sd18,  8'sd15,  8'sd12,   8'sd9,   8'sd6,   8'sd3
  };

  function automatic logic [PHASE_W-1:0] step_inc(input scale_t row, input logic [2:0] col);
    logic [PHASE_W-1:0] inc;
    case (row)
      SCALE_MAJOR:      inc = STEP_MAJOR[col];
      SCALE_MINOR:      inc = STEP_MINOR[col];
      SCALE_DORIAN:     inc = STEP_DORIAN[col];
      SCALE_MIXOLYDIAN: inc = STEP_MIXO[col];
      default:          inc = STEP_MAJOR[col];
    endcase
    return inc;
  endfunction

  // Any choice past saw plays saw.
  function automatic wave_kind_t clamp_kind(input logic [1:0] choice);
    wave_kind_t kind;
    case (choice)
      2'(WAVE_SINE):   kind = WAVE_SINE;
      2'(WAVE_SQUARE): kind = WAVE_SQUARE;
      default:         kind = WAVE_SAW;
    endcase
    return kind;
  endfunction

  function automatic logic signed [7:0] wave_value(input wave_kind_t kind,
                                                   input logic [ROM_IDX_W-1:0] idx);
    logic signed [7:0] half;
    logic signed [7:0] val;
    half = SINE_HALF[idx[6:0]];
    case (kind)
      WAVE_SINE:   val = idx[7] ? -half : half;
      WAVE_SQUARE: val = (idx < ROM_IDX_W'(SQUARE_EDGE)) ? -8'sd128 : 8'sd127;
      WAVE_SAW:    val = $signed({~idx[7], idx[6:0]});
      default:     val = $signed({~idx[7], idx[6:0]});
    endcase
    return val;
  endfunction

endpackage

/* rtl/pwmix_lane.sv */
// ----------------------------------------------------------------------------
// pwmix_lane
// One voice: phase accumulator, table index scaling and wave lookup.
// ----------------------------------------------------------------------------
module pwmix_lane #(
  parameter int VOICE_INDEX  = 0,
  parameter int WAVE_ENTRIES = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pwmix_pkg::stage_ctrl_t  ctrl,
  input  logic                    gate,
  input  pwmix_pkg::wave_kind_t   kind,
  input  pwmix_pkg::scale_t       row,
  output logic signed [7:0]       sample
);

  localparam int WE_W    = $clog2(WAVE_ENTRIES + 1);
  localparam int STEP_W  = $clog2(WAVE_ENTRIES);
  localparam int N_W     = STEP_W + pwmix_pkg::ROM_IDX_W;
  localparam int RCP_SH  = 24;
  localparam int RCP_W   = RCP_SH + 1;
  localparam int P3_W    = N_W + RCP_W;
  localparam int R_W     = pwmix_pkg::ROM_IDX_W + WE_W + 1;
  localparam logic [WE_W-1:0]  WE_VAL  = WE_W'(WAVE_ENTRIES);
  localparam logic [RCP_W-1:0] RCP_VAL = RCP_W'((64'd1 << RCP_SH) / WAVE_ENTRIES);
  localparam logic [2:0]       COL     = 3'(VOICE_INDEX % pwmix_pkg::SCALE_COLS);

  logic [pwmix_pkg::PHASE_W-1:0] phase, phase_next;

  // stage 1
  logic [pwmix_pkg::PHASE_W-1:0] ph1;
  logic                          g1;
  pwmix_pkg::wave_kind_t         k1;
  // stage 2
  logic [N_W-1:0]                n2;
  logic                          g2;
  pwmix_pkg::wave_kind_t         k2;
  // stage 3
  logic [N_W-1:0]                n3;
  logic [pwmix_pkg::ROM_IDX_W-1:0] q3;
  logic                          g3;
  pwmix_pkg::wave_kind_t         k3;

  logic [pwmix_pkg::PHASE_W+WE_W-1:0] mul1;
  logic [P3_W-1:0]                    prod3;
  logic [pwmix_pkg::ROM_IDX_W+WE_W-1:0] qw;
  logic [R_W-1:0]                     rem;
  logic [pwmix_pkg::ROM_IDX_W-1:0]    idx;

  assign phase_next = phase + pwmix_pkg::step_inc(row, COL);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (ctrl.accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      ph1 <= phase_next;
      g1  <= gate;
      k1  <= kind;
    end
  end

  // steps = phase * entries >> 16, then scaled by 256 toward the ROM
  assign mul1 = ph1 * WE_VAL;

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      n2 <= {mul1[pwmix_pkg::PHASE_W +: STEP_W], {pwmix_pkg::ROM_IDX_W{1'b0}}};
      g2 <= g1;
      k2 <= k1;
    end
  end

  // quotient estimate by reciprocal; low by at most one
  assign prod3 = n2 * RCP_VAL;

  always_ff @(posedge clk) begin
    if (ctrl.en3) begin
      n3 <= n2;
      q3 <= prod3[RCP_SH +: pwmix_pkg::ROM_IDX_W];
      g3 <= g2;
      k3 <= k2;
    end
  end

  always_comb begin
    qw  = q3 * WE_VAL;
    rem = R_W'(n3) - R_W'(qw);
    idx = (rem >= R_W'(WAVE_ENTRIES)) ? q3 + 1'b1 : q3;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en4) begin
      sample <= g3 ? pwmix_pkg::wave_value(k3, idx) : 8'sd0;
    end
  end

endmodule

/* rtl/pwmix_merge.sv */
// ----------------------------------------------------------------------------
// pwmix_merge
// Sums the lane samples, adds the DC offset, clamps and registers the DAC code.
// ----------------------------------------------------------------------------
module pwmix_merge #(
  parameter int VOICE_COUNT = 8
) (
  input  logic              clk,
  input  logic              load,
  input  logic signed [7:0] samples [VOICE_COUNT],
  output logic [7:0]        dac_sample
);

  localparam int SUM_W = $clog2(VOICE_COUNT) + 12;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] mixed;
  logic [7:0]              dac_next;

  always_comb begin
    sum = '0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      sum = sum + SUM_W'(samples[i]);
    end
    mixed = sum + SUM_W'(pwmix_pkg::MIX_OFFSET);
    if (mixed < 0) begin
      dac_next = '0;
    end else if (mixed > SUM_W'(pwmix_pkg::MIX_MAX)) begin
      dac_next = 8'(pwmix_pkg::MIX_MAX >> pwmix_pkg::DAC_SHIFT);
    end else begin
      dac_next = mixed[pwmix_pkg::DAC_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dac_sample <= dac_next;
    end
  end

endmodule

/* rtl/polyphonic_wavetable_mixer.sv */
// ----------------------------------------------------------------------------
// polyphonic_wavetable_mixer
// Multi-voice DDS synthesizer with gated mix to an unsigned 8-bit DAC code.
// ----------------------------------------------------------------------------
// Usage:
//   Tick channel (tick_valid / tick_stall): one transaction per sample tick,
//   carrying note_gates, scale_choice and wave_choice. Every voice phase
//   advances on each accepted tick, gated or not.
//   DAC channel (dac_valid / dac_stall): one transaction per tick, dac_sample.
// Pipeline: an accepted tick passes four lane stages plus the mix register,
//   then shows its sample with dac_valid.
// Throughput: one tick per clock unless stalled; all voices run in parallel
//   lanes, the only loop-carried path being the 16-bit phase add on accept.
// Stall: each stage holds only when its successor is full and holding, so
//   bubbles collapse and new ticks are still taken while a sample waits.
//   tick_stall rises only when the whole pipe is full behind a stalled output.
// Reset (rst, synchronous): all phases clear to zero, pipe empties.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_mixer #(
  parameter int VOICE_COUNT  = 8,
  parameter int WAVE_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick_valid,
  output logic       tick_stall,
  input  logic [7:0] note_gates,
  input  logic [1:0] scale_choice,
  input  logic [1:0] wave_choice,
  output logic       dac_valid,
  input  logic       dac_stall,
  output logic [7:0] dac_sample
);

  // stage occupancy
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en_dac;
  logic accept;

  pwmix_pkg::stage_ctrl_t ctrl;
  pwmix_pkg::wave_kind_t  kind;
  pwmix_pkg::scale_t      row;

  logic signed [7:0] lane_sample [VOICE_COUNT];

  // Bubble-collapsing enables: a stage loads when empty or when it drains.
  assign en_dac = !dac_valid || !dac_stall;
  assign en4    = !v4 || en_dac;
  assign en3    = !v3 || en4;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;

  assign tick_stall = !en1;
  assign accept     = tick_valid && en1;

  assign ctrl.accept = accept;
  assign ctrl.en2    = en2;
  assign ctrl.en3    = en3;
  assign ctrl.en4    = en4;

  assign kind = pwmix_pkg::clamp_kind(wave_choice);
  assign row  = pwmix_pkg::scale_t'(scale_choice);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      dac_valid <= 1'b0;
    end else begin
      if (en1)    v1        <= tick_valid;
      if (en2)    v2        <= v1;
      if (en3)    v3        <= v2;
      if (en4)    v4        <= v3;
      if (en_dac) dac_valid <= v4;
    end
  end

  // One lane per voice; voices past the gate field never sound.
  for (genvar i = 0; i < VOICE_COUNT; i++) begin : g_lane
    logic gate;
    if (i < pwmix_pkg::GATE_BITS) begin : g_gated
      assign gate = note_gates[i];
    end else begin : g_mute
      assign gate = 1'b0;
    end

    pwmix_lane #(
      .VOICE_INDEX  (i),
      .WAVE_ENTRIES (WAVE_ENTRIES)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .gate   (gate),
      .kind   (kind),
      .row    (row),
      .sample (lane_sample[i])
    );
  end

  pwmix_merge #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_merge (
    .clk        (clk),
    .load       (en_dac),
    .samples    (lane_sample),
    .dac_sample (dac_sample)
  );

  // An empty pipe never pushes back on the tick channel.
  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    (!v1 && !v2 && !v3 && !v4 && !dac_valid) |-> !tick_stall)
    else $error("tick stalled with empty pipe");

  // An accepted tick occupies the first stage next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && !tick_stall) |=> v1)
    else $error("accepted tick lost at stage 1");

  // A finished lane result moves to the output when the output can take it.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (v4 && !(dac_valid && dac_stall)) |=> dac_valid)
    else $error("lane result not presented");

endmodule
